// ===== rtl/fsad_pkg.sv =====
// Shared types and constants of the frame sound activity detector.
`default_nettype none
package fsad_pkg;

  localparam int SAMPLE_W = 16;
  localparam int COUNT_W  = 13;
  localparam int SUM_W    = 28;
  localparam int CAL_W    = 5;

  localparam logic [COUNT_W-1:0] MAX_CHUNK  = 13'd4096;
  localparam logic [CAL_W-1:0]   CAL_CHUNKS = 5'd20;

  localparam logic [COUNT_W-1:0] CHUNK_SAMPLES_RST  = 13'd512;
  localparam logic [15:0]        BASE_THRESHOLD_RST = 16'd500;
  localparam logic [7:0]         ATTACK_FRAMES_RST  = 8'd3;
  localparam logic [7:0]         RELEASE_FRAMES_RST = 8'd10;

  localparam int DIV_STEPS = SUM_W;
  localparam int STEP_W    = 5;

  // Multiplying by RECIP_FIVE and shifting right by RECIP_FIVE_SHIFT divides by five
  // exactly for every dividend below two to the eighteenth.
  localparam logic [16:0] RECIP_FIVE       = 17'd52429;
  localparam int          RECIP_FIVE_SHIFT = 18;

  typedef enum logic [1:0] {
    REG_CHUNK_SAMPLES  = 2'd0,
    REG_BASE_THRESHOLD = 2'd1,
    REG_ATTACK_FRAMES  = 2'd2,
    REG_RELEASE_FRAMES = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [SUM_W-1:0]           abs_sum;
    logic [COUNT_W-1:0]         count;
    logic signed [SAMPLE_W-1:0] cmin;
    logic signed [SAMPLE_W-1:0] cmax;
    logic                       speech;
  } chunk_rec_t;

  typedef struct packed {
    logic               start;
    logic [SUM_W-1:0]   dividend;
    logic [COUNT_W-1:0] divisor;
  } div_req_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_LEVEL,
    BK_FLOOR,
    BK_SCALE,
    BK_EMIT
  } back_state_t;

endpackage
`default_nettype wire

// ===== rtl/fsad_front.sv =====
// Front end: accumulates samples into chunks and emits one chunk record per chunk.
`default_nettype none
module fsad_front
  import fsad_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [COUNT_W-1:0]         chunk_samples,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic signed [SAMPLE_W-1:0] sample,
  input  wire logic                       speech_flag,
  input  wire logic                       fifo_full,
  output logic                            push,
  output chunk_rec_t                      rec
);

  logic [SUM_W-1:0]           abs_sum;
  logic signed [SAMPLE_W-1:0] cmin;
  logic signed [SAMPLE_W-1:0] cmax;
  logic [COUNT_W-1:0]         sample_index;

  logic [COUNT_W-1:0]         eff_len;
  logic [SAMPLE_W:0]          neg_sample;
  logic [SAMPLE_W-1:0]        abs_val;
  logic [SUM_W-1:0]           abs_sum_next;
  logic signed [SAMPLE_W-1:0] cmin_next;
  logic signed [SAMPLE_W-1:0] cmax_next;
  logic [COUNT_W-1:0]         index_next;
  logic                       accept;
  logic                       close;

  always_comb begin
    if (chunk_samples == '0) begin
      eff_len = COUNT_W'(1);
    end else if (chunk_samples > MAX_CHUNK) begin
      eff_len = MAX_CHUNK;
    end else begin
      eff_len = chunk_samples;
    end
  end

  assign in_ready     = !fifo_full;
  assign accept       = in_valid && in_ready;
  assign neg_sample   = (SAMPLE_W+1)'(0) - {sample[SAMPLE_W-1], sample};
  assign abs_val      = sample[SAMPLE_W-1] ? neg_sample[SAMPLE_W-1:0] : sample;
  assign abs_sum_next = abs_sum + SUM_W'(abs_val);
  assign cmin_next    = (sample < cmin) ? sample : cmin;
  assign cmax_next    = (sample > cmax) ? sample : cmax;
  assign index_next   = sample_index + COUNT_W'(1);
  assign close        = index_next >= eff_len;
  assign push         = accept && close;

  always_comb begin
    rec.abs_sum = abs_sum_next;
    rec.count   = index_next;
    rec.cmin    = cmin_next;
    rec.cmax    = cmax_next;
    rec.speech  = speech_flag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      abs_sum      <= '0;
      cmin         <= 16'sh7FFF;
      cmax         <= 16'sh8000;
      sample_index <= '0;
    end else if (accept) begin
      if (close) begin
        abs_sum      <= '0;
        cmin         <= 16'sh7FFF;
        cmax         <= 16'sh8000;
        sample_index <= '0;
      end else begin
        abs_sum      <= abs_sum_next;
        cmin         <= cmin_next;
        cmax         <= cmax_next;
        sample_index <= index_next;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/fsad_fifo.sv =====
// Two-entry queue of chunk records between the front end and the back end.
`default_nettype none
module fsad_fifo
  import fsad_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  chunk_rec_t      wr_rec,
  output logic            full,
  input  wire logic       pop,
  output chunk_rec_t      rd_rec,
  output logic            empty
);

  chunk_rec_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full   = fill == 2'd2;
  assign empty  = fill == 2'd0;
  assign rd_rec = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/fsad_div.sv =====
// Shared restoring divider producing one quotient bit per cycle.
`default_nettype none
module fsad_div
  import fsad_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  div_req_t           req,
  output logic               done,
  output logic [SUM_W-1:0]   quotient
);

  logic               busy;
  logic [STEP_W-1:0]  step;
  logic [COUNT_W-1:0] rem;
  logic [COUNT_W-1:0] divisor;
  logic [COUNT_W:0]   trial;
  logic [COUNT_W:0]   diff;
  logic               qbit;
  logic [COUNT_W-1:0] rem_next;

  always_comb begin
    trial = {rem, quotient[SUM_W-1]};
    diff  = trial - {1'b0, divisor};
    qbit  = trial >= {1'b0, divisor};
    rem_next = qbit ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quotient <= req.dividend;
      divisor  <= req.divisor;
      rem      <= '0;
    end else if (busy) begin
      quotient <= {quotient[SUM_W-2:0], qbit};
      rem      <= rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + STEP_W'(1);
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/fsad_back.sv =====
// Back end: chunk statistics, noise floor calibration, debounce and result register.
`default_nettype none
module fsad_back
  import fsad_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic [15:0]  base_threshold,
  input  wire logic [7:0]   attack_frames,
  input  wire logic [7:0]   release_frames,
  input  wire logic         fifo_empty,
  input  chunk_rec_t        fifo_rec,
  output logic              pop,
  output div_req_t          div_req,
  input  wire logic         div_done,
  input  wire logic [SUM_W-1:0] div_quotient,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [15:0]       level,
  output logic [15:0]       peak_to_peak,
  output logic [15:0]       noise_floor,
  output logic [15:0]       threshold,
  output logic              calibrating,
  output logic              sound_detected,
  output logic [15:0]       active_frames
);

  back_state_t state;
  back_state_t state_next;

  chunk_rec_t       rec;
  logic [15:0]      level_q;
  logic             cal_chunk;
  logic [15:0]      floor_level;
  logic [CAL_W-1:0] cal_count;
  logic [15:0]      dyn_threshold;
  logic [15:0]      sound_run;
  logic [15:0]      quiet_run;
  logic             detected_flag;

  logic [15:0]      quo16;
  logic [20:0]      floor_prod;
  logic [21:0]      floor_sum;
  logic [18:0]      floor_x6;
  logic [35:0]      scaled_prod;
  logic [15:0]      scaled;
  logic             load_out;
  logic             is_sound;
  logic [15:0]      sound_run_next;
  logic [15:0]      quiet_run_next;
  logic             detected_next;
  logic [16:0]      p2p_full;

  assign quo16       = div_quotient[15:0];
  assign floor_prod  = 21'(floor_level) * 21'(cal_count);
  assign floor_sum   = 22'(floor_prod) + 22'(quo16);
  assign floor_x6    = 19'(floor_level) * 19'd6;
  assign scaled_prod = 36'(floor_x6) * 36'(RECIP_FIVE);
  assign scaled      = scaled_prod[RECIP_FIVE_SHIFT +: 16];
  assign p2p_full    = 17'(rec.cmax) - 17'(rec.cmin);

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    load_out   = 1'b0;
    div_req    = '0;
    unique case (state)
      BK_IDLE: begin
        if (!fifo_empty) begin
          pop              = 1'b1;
          div_req.start    = 1'b1;
          div_req.dividend = fifo_rec.abs_sum;
          div_req.divisor  = fifo_rec.count;
          state_next       = BK_LEVEL;
        end
      end
      BK_LEVEL: begin
        if (div_done) begin
          if (cal_count < CAL_CHUNKS) begin
            div_req.start    = 1'b1;
            div_req.dividend = SUM_W'(floor_sum);
            div_req.divisor  = COUNT_W'(cal_count) + COUNT_W'(1);
            state_next       = BK_FLOOR;
          end else begin
            state_next = BK_EMIT;
          end
        end
      end
      BK_FLOOR: begin
        if (div_done) begin
          if (cal_count == CAL_CHUNKS - CAL_W'(1)) begin
            state_next = BK_SCALE;
          end else begin
            state_next = BK_EMIT;
          end
        end
      end
      BK_SCALE: begin
        state_next = BK_EMIT;
      end
      BK_EMIT: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_comb begin
    is_sound       = rec.speech || (level_q >= dyn_threshold);
    sound_run_next = sound_run;
    quiet_run_next = quiet_run;
    detected_next  = detected_flag;
    if (cal_chunk) begin
      detected_next = 1'b0;
    end else if (is_sound) begin
      if (sound_run != 16'hFFFF) begin
        sound_run_next = sound_run + 16'd1;
      end
      quiet_run_next = '0;
      if (sound_run_next >= 16'(attack_frames)) begin
        detected_next = 1'b1;
      end
    end else begin
      if (quiet_run != 16'hFFFF) begin
        quiet_run_next = quiet_run + 16'd1;
      end
      sound_run_next = '0;
      if (quiet_run_next >= 16'(release_frames)) begin
        detected_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rec <= fifo_rec;
    end
    if (state == BK_LEVEL && div_done) begin
      level_q   <= quo16;
      cal_chunk <= cal_count < CAL_CHUNKS;
    end
    if (load_out) begin
      level        <= level_q;
      peak_to_peak <= p2p_full[15:0];
      noise_floor  <= floor_level;
      threshold    <= dyn_threshold;
      calibrating  <= cal_count < CAL_CHUNKS;
      sound_detected <= detected_next;
      active_frames  <= sound_run_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      floor_level   <= '0;
      cal_count     <= '0;
      dyn_threshold <= BASE_THRESHOLD_RST;
      sound_run     <= '0;
      quiet_run     <= '0;
      detected_flag <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (state == BK_FLOOR && div_done) begin
        floor_level <= quo16;
        cal_count   <= cal_count + CAL_W'(1);
      end
      if (state == BK_SCALE) begin
        dyn_threshold <= (scaled > base_threshold) ? scaled : base_threshold;
      end
      if (load_out) begin
        sound_run     <= sound_run_next;
        quiet_run     <= quiet_run_next;
        detected_flag <= detected_next;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/frame_sound_activity_detector_core.sv =====
// Top level of the frame sound activity detector with its configuration registers.
// The block takes one sample beat per cycle and closes a chunk after the configured
// number of samples, clamped to 1 to 4096; each chunk yields one status beat. The
// back end works a chunk through a shared divider that produces one quotient bit per
// cycle: a normal chunk needs one division, a calibration chunk two, and the last
// calibration chunk also a scaling step, where the threshold is scaled by six fifths
// with a reciprocal multiply. A two-entry chunk queue sits between the sample front
// end and the back end, so input stalls only when chunks shorter than the back-end
// time for a chunk arrive in a row or when status beats are not taken.
// Configuration writes are taken every cycle; there is no clearing pass after reset.
`default_nettype none
module frame_sound_activity_detector_core
  import fsad_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic signed [15:0] sample,
  input  wire logic        speech_flag,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      level,
  output logic [15:0]      peak_to_peak,
  output logic [15:0]      noise_floor,
  output logic [15:0]      threshold,
  output logic             calibrating,
  output logic             sound_detected,
  output logic [15:0]      active_frames
);

  logic [COUNT_W-1:0] chunk_samples;
  logic [15:0]        base_threshold;
  logic [7:0]         attack_frames;
  logic [7:0]         release_frames;

  logic               fifo_full;
  logic               fifo_empty;
  logic               push;
  logic               pop;
  chunk_rec_t         wr_rec;
  chunk_rec_t         rd_rec;
  div_req_t           div_req;
  logic               div_done;
  logic [SUM_W-1:0]   div_quotient;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_samples  <= CHUNK_SAMPLES_RST;
      base_threshold <= BASE_THRESHOLD_RST;
      attack_frames  <= ATTACK_FRAMES_RST;
      release_frames <= RELEASE_FRAMES_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CHUNK_SAMPLES:  chunk_samples  <= cfg_data[COUNT_W-1:0];
        REG_BASE_THRESHOLD: base_threshold <= cfg_data;
        REG_ATTACK_FRAMES:  attack_frames  <= cfg_data[7:0];
        REG_RELEASE_FRAMES: release_frames <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  fsad_front u_front (
    .clk           (clk),
    .rst           (rst),
    .chunk_samples (chunk_samples),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .sample        (sample),
    .speech_flag   (speech_flag),
    .fifo_full     (fifo_full),
    .push          (push),
    .rec           (wr_rec)
  );

  fsad_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_rec (wr_rec),
    .full   (fifo_full),
    .pop    (pop),
    .rd_rec (rd_rec),
    .empty  (fifo_empty)
  );

  fsad_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quotient)
  );

  fsad_back u_back (
    .clk            (clk),
    .rst            (rst),
    .base_threshold (base_threshold),
    .attack_frames  (attack_frames),
    .release_frames (release_frames),
    .fifo_empty     (fifo_empty),
    .fifo_rec       (rd_rec),
    .pop            (pop),
    .div_req        (div_req),
    .div_done       (div_done),
    .div_quotient   (div_quotient),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .level          (level),
    .peak_to_peak   (peak_to_peak),
    .noise_floor    (noise_floor),
    .threshold      (threshold),
    .calibrating    (calibrating),
    .sound_detected (sound_detected),
    .active_frames  (active_frames)
  );

endmodule
`default_nettype wire
